// ===== hw/rtl/brf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring FIFO with end-of-stream mark.
// ----------------------------------------------------------------------------
package brf_pkg;

    // Payload widths
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 10;

    // Default store depth in bytes
    localparam int DEFAULT_BUFFER_BYTES = 1024;

    // Operation codes
    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_READ     = 2'd1,
        OP_FLUSH    = 2'd2,
        OP_COMPLETE = 2'd3
    } t_op;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESULT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming operation
        logic exec;   // apply the captured operation
    } t_dp_cmd;

endpackage
`default_nettype wire

// ===== hw/rtl/brf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brf_ctrl
// Sequencer: accepts a command, runs it in the execute state, then strobes the
// result while already able to take the next command.
// ----------------------------------------------------------------------------
module brf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    output logic                  o_done,
    output brf_pkg::t_dp_cmd      o_cmd
);
    import brf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Accept a command when not busy
    assign accept = start && !busy;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                n_state = start ? ST_EXEC : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        busy       = 1'b0;
        o_done     = 1'b0;
        o_cmd.exec = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_EXEC: begin
                busy       = 1'b1;
                o_cmd.exec = 1'b1;
            end
            ST_RESULT: begin
                o_done = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
        o_cmd.load = start && !busy;
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted command always runs an execute cycle next
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_EXEC)
        else $error("accepted command did not enter execute");

    // Every execute cycle is followed by exactly one result strobe
    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_done && !o_cmd.exec)
        else $error("execute not followed by result strobe");

    // No strobe without a preceding execute cycle
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_cmd.exec))
        else $error("result strobe without execute");

endmodule
`default_nettype wire

// ===== hw/rtl/brf_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brf_datapath
// Byte store, read and write cursors, end-of-stream mark and result
// registers. One slot stays empty so equal cursors mean empty.
// ----------------------------------------------------------------------------
module brf_datapath #(
    parameter int BUFFER_BYTES = brf_pkg::DEFAULT_BUFFER_BYTES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire brf_pkg::t_dp_cmd            i_cmd,
    input  wire logic [1:0]                  i_operation,
    input  wire logic [brf_pkg::BYTE_W-1:0]  i_write_byte,
    output logic [brf_pkg::BYTE_W-1:0]       o_read_byte,
    output logic                             o_read_valid,
    output logic                             o_stream_ended,
    output logic                             o_write_dropped,
    output logic [brf_pkg::COUNT_W-1:0]      o_used_count,
    output logic [brf_pkg::COUNT_W-1:0]      o_free_count
);
    import brf_pkg::*;

    localparam int PTR_W = $clog2(BUFFER_BYTES);
    localparam int EXT_W = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(BUFFER_BYTES - 1);

    // Byte store
    logic [BYTE_W-1:0] r_mem [BUFFER_BYTES];
    logic [BYTE_W-1:0] r_rd_data;

    // Cursors and mark
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic             r_complete, n_complete;

    // Captured command
    t_op               r_op;
    logic [BYTE_W-1:0] r_wbyte;

    // Result flags
    logic r_read_valid, n_read_valid;
    logic r_write_dropped, n_write_dropped;

    logic [PTR_W:0]   wrap_sum;
    logic [PTR_W-1:0] used;
    logic [PTR_W-1:0] free;
    logic [EXT_W-1:0] used_ext;
    logic [EXT_W-1:0] free_ext;
    logic             empty;
    logic             full;
    logic             wr_ok;
    logic             rd_ok;

    // Held bytes from the cursors, wrapping at the store depth
    assign wrap_sum = {1'b0, r_wr_ptr} + (PTR_W+1)'(BUFFER_BYTES) - {1'b0, r_rd_ptr};
    assign used     = (r_wr_ptr >= r_rd_ptr) ? (r_wr_ptr - r_rd_ptr) : wrap_sum[PTR_W-1:0];
    assign free     = LAST_SLOT - used;
    assign empty    = (r_wr_ptr == r_rd_ptr);
    assign full     = (used >= LAST_SLOT);

    assign wr_ok = i_cmd.exec && (r_op == OP_WRITE) && !r_complete && !full;
    assign rd_ok = i_cmd.exec && (r_op == OP_READ) && !empty;

    // Next cursor, mark and flag values
    always_comb begin
        n_rd_ptr        = r_rd_ptr;
        n_wr_ptr        = r_wr_ptr;
        n_complete      = r_complete;
        n_read_valid    = r_read_valid;
        n_write_dropped = r_write_dropped;
        if (i_cmd.exec) begin
            n_read_valid    = rd_ok;
            n_write_dropped = (r_op == OP_WRITE) && !wr_ok;
            case (r_op)
                OP_WRITE: begin
                    if (wr_ok) n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
                end
                OP_READ: begin
                    if (rd_ok) n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
                end
                OP_FLUSH: begin
                    n_rd_ptr = '0;
                    n_wr_ptr = '0;
                end
                OP_COMPLETE: begin
                    n_complete = 1'b1;
                end
                default: begin
                    n_complete = r_complete;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr        <= '0;
            r_wr_ptr        <= '0;
            r_complete      <= 1'b0;
            r_read_valid    <= 1'b0;
            r_write_dropped <= 1'b0;
        end else begin
            r_rd_ptr        <= n_rd_ptr;
            r_wr_ptr        <= n_wr_ptr;
            r_complete      <= n_complete;
            r_read_valid    <= n_read_valid;
            r_write_dropped <= n_write_dropped;
        end
    end

    // Capture the command on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_operation);
            r_wbyte <= i_write_byte;
        end
    end

    // Store write port and registered read at the read cursor
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= r_wbyte;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    // Drive results, counts masked to the port width
    assign used_ext        = EXT_W'(used);
    assign free_ext        = EXT_W'(free);
    assign o_read_byte     = r_read_valid ? r_rd_data : '0;
    assign o_read_valid    = r_read_valid;
    assign o_write_dropped = r_write_dropped;
    assign o_stream_ended  = r_complete && empty;
    assign o_used_count    = used_ext[COUNT_W-1:0];
    assign o_free_count    = free_ext[COUNT_W-1:0];

    // A read and a refused write never report together
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_read_valid && r_write_dropped))
        else $error("read valid and write dropped both set");

    // A flush leaves both cursors at zero
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && r_op == OP_FLUSH |=> r_rd_ptr == '0 && r_wr_ptr == '0)
        else $error("flush did not clear cursors");

    // Once complete is marked, the write cursor never advances
    a_no_wr_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_complete && i_cmd.exec && r_op == OP_WRITE |=> $stable(r_wr_ptr) && r_write_dropped)
        else $error("write accepted after stream complete");

endmodule
`default_nettype wire

// ===== hw/rtl/byte_ring_fifo_with_end_mark_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_end_mark_unit
// Byte ring FIFO with read and write cursors and an end-of-stream mark.
// ----------------------------------------------------------------------------
// A command (write, read, flush, mark complete) is taken at a clock edge with
// start high and busy low. The next cycle executes it against the byte store,
// and the cycle after that shows the result on the o_ ports with o_done high
// for exactly one cycle; the receiver cannot stall and must take it then.
// busy is low during that result cycle, so a new command may be taken there,
// but busy is high while a command executes, so none is taken before then.
// One slot stays empty, so at most BUFFER_BYTES-1 bytes are held. Counts on
// the ports are the low 10 bits of the true values.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_end_mark_unit #(
    parameter int BUFFER_BYTES = brf_pkg::DEFAULT_BUFFER_BYTES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_operation,
    input  wire logic [brf_pkg::BYTE_W-1:0]  i_write_byte,
    output logic                             o_done,
    output logic [brf_pkg::BYTE_W-1:0]       o_read_byte,
    output logic                             o_read_valid,
    output logic                             o_stream_ended,
    output logic                             o_write_dropped,
    output logic [brf_pkg::COUNT_W-1:0]      o_used_count,
    output logic [brf_pkg::COUNT_W-1:0]      o_free_count
);
    import brf_pkg::*;

    t_dp_cmd cmd;

    // Sequencer
    brf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // Store, cursors and results
    brf_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operation     (i_operation),
        .i_write_byte    (i_write_byte),
        .o_read_byte     (o_read_byte),
        .o_read_valid    (o_read_valid),
        .o_stream_ended  (o_stream_ended),
        .o_write_dropped (o_write_dropped),
        .o_used_count    (o_used_count),
        .o_free_count    (o_free_count)
    );

endmodule
`default_nettype wire
